// ===== hw/rtl/ipd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

  // configuration port
  localparam int CFG_W   = 11;
  localparam int CFG_IW  = 1;
  localparam logic [CFG_IW-1:0] CFG_FRAME_ROWS = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_COLS = 1'b1;
  localparam logic [CFG_W-1:0]  CFG_SIZE_RESET = 11'd1024;

  // default geometry
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // result fields
  localparam int COORD_W = 10;
  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  // window: number of stored columns behind the incoming one
  localparam int WIN_COLS = 2;
  localparam int COL_BITS = 3;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] hit_row;
    logic [COORD_W-1:0] hit_col;
    logic [COUNT_W-1:0] hit_count;
    logic               last;
  } ipd_result_t;

  // what the compute stage pushes into the result queue in one cycle
  typedef struct packed {
    logic push_a;
    logic push_b;
  } ipd_push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/isolated_pixel_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  pixel
// output    out_valid/ out_stall kind, hit_row, hit_col, hit_count, last
// config    cfg_write            cfg_index, cfg_data
//
// One pixel per clock while in_stall is low; results pass the compute stage, then the queue.
// The line buffers take one read and one write per cycle; a frame-end pixel
// with a hit gives two results, absorbed by a four-entry result queue.
// Reset clears position, count, window and queue; line buffers are not cleared.
// in_stall rises only while the queue lacks room for two results.
module isolated_pixel_detector #(
  parameter int MAX_COLS = ipd_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = ipd_pkg::DEF_MAX_ROWS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [ipd_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [ipd_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         pixel,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              kind,
  output logic      [ipd_pkg::COORD_W-1:0]  hit_row,
  output logic      [ipd_pkg::COORD_W-1:0]  hit_col,
  output logic      [ipd_pkg::COUNT_W-1:0]  hit_count,
  output logic                              last
);

  import ipd_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CSW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
  localparam int RSW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
  localparam logic [8:0] ISO_PATTERN = 9'b000_000_010;

  // configuration
  logic [CFG_W-1:0] frame_rows;
  logic [CFG_W-1:0] frame_cols;
  logic [RSW-1:0]   eff_rows;
  logic [CSW-1:0]   eff_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= CFG_SIZE_RESET;
      frame_cols <= CFG_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_ROWS: frame_rows <= cfg_data;
        CFG_FRAME_COLS: frame_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_rows == '0) begin
      eff_rows = RSW'(1);
    end else if (RSW'(frame_rows) > RSW'(MAX_ROWS)) begin
      eff_rows = RSW'(MAX_ROWS);
    end else begin
      eff_rows = RSW'(frame_rows);
    end
    if (frame_cols == '0) begin
      eff_cols = CSW'(1);
    end else if (CSW'(frame_cols) > CSW'(MAX_COLS)) begin
      eff_cols = CSW'(MAX_COLS);
    end else begin
      eff_cols = CSW'(frame_cols);
    end
  end

  // raster position, updated on each input transfer
  logic [CW-1:0] col_index;
  logic [RW-1:0] row_index;
  logic          row_end;
  logic          frame_end;
  logic          in_xfer;

  assign in_xfer   = in_valid && !in_stall;
  assign row_end   = (CSW'(col_index) + CSW'(1)) >= eff_cols;
  assign frame_end = row_end && ((RSW'(row_index) + RSW'(1)) >= eff_rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
    end else if (in_xfer) begin
      if (frame_end) begin
        col_index <= '0;
        row_index <= '0;
      end else if (row_end) begin
        col_index <= '0;
        row_index <= row_index + RW'(1);
      end else begin
        col_index <= col_index + CW'(1);
      end
    end
  end

  // compute stage
  logic          s1_valid;
  logic          s1_fire;
  logic          s1_px;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_row_end;
  logic          s1_frame_end;
  logic          rq_room2;

  assign s1_fire  = s1_valid && rq_room2;
  assign in_stall = s1_valid && !rq_room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_px        <= pixel;
      s1_col       <= col_index;
      s1_row       <= row_index;
      s1_row_end   <= row_end;
      s1_frame_end <= frame_end;
    end
  end

  // bit 1: two rows above, bit 0: one row above
  logic [1:0] line_rd;

  ipd_line_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (2)
  ) u_line_mem (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata ({line_rd[0], s1_px}),
    .re    (in_xfer),
    .raddr (col_index),
    .rdata (line_rd)
  );

  // window: chain[0] is the incoming column, chain[i] is column c-i
  logic [COL_BITS-1:0] chain [WIN_COLS+1];

  assign chain[0] = {s1_px, line_rd[0], line_rd[1]};

  for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
    ipd_col_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (s1_fire),
      .clear   (s1_row_end),
      .col_in  (chain[i]),
      .col_out (chain[i+1])
    );
  end

  logic [8:0]         win9;
  logic               hit;
  logic [COUNT_W-1:0] found_total;
  logic [COUNT_W-1:0] total_next;
  logic [RW-1:0]      row_m1;
  logic [CW-1:0]      col_m1;

  assign win9 = {chain[0], chain[2], chain[1]};
  assign hit  = (s1_row >= RW'(2)) && (s1_col >= CW'(2)) && (win9 == ISO_PATTERN);
  assign total_next = (hit && (found_total != COUNT_MAX)) ? found_total + COUNT_W'(1)
                                                           : found_total;
  assign row_m1 = s1_row - RW'(1);
  assign col_m1 = s1_col - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      found_total <= '0;
    end else if (s1_fire) begin
      if (s1_frame_end) begin
        found_total <= '0;
      end else begin
        found_total <= total_next;
      end
    end
  end

  ipd_push_t   rq_push;
  ipd_result_t res_hit;
  ipd_result_t res_total;
  ipd_result_t rq_a;
  ipd_result_t rq_out;

  always_comb begin
    res_hit.kind        = KIND_HIT;
    res_hit.hit_row     = COORD_W'(row_m1);
    res_hit.hit_col     = COORD_W'(col_m1);
    res_hit.hit_count   = total_next;
    res_hit.last        = !s1_frame_end;

    res_total.kind      = KIND_TOTAL;
    res_total.hit_row   = '0;
    res_total.hit_col   = '0;
    res_total.hit_count = total_next;
    res_total.last      = 1'b1;

    rq_a           = hit ? res_hit : res_total;
    rq_push.push_a = s1_fire && (hit || s1_frame_end);
    rq_push.push_b = s1_fire && hit && s1_frame_end;
  end

  ipd_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .data_a    (rq_a),
    .data_b    (res_total),
    .room2     (rq_room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (rq_out)
  );

  assign kind      = rq_out.kind;
  assign hit_row   = rq_out.hit_row;
  assign hit_col   = rq_out.hit_col;
  assign hit_count = rq_out.hit_count;
  assign last      = rq_out.last;

endmodule

`default_nettype wire

// ===== hw/rtl/ipd_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line buffer memory: one write and one registered read per cycle.
// A read of the address being written returns the new data.
module ipd_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipd_col_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One column of the 3x3 window (top, middle, bottom). Shifts its column
// to the next cell on every processed pixel; cleared at row end.
module ipd_col_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         shift,
  input  wire logic                         clear,
  input  wire logic [ipd_pkg::COL_BITS-1:0] col_in,
  output logic      [ipd_pkg::COL_BITS-1:0] col_out
);

  import ipd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      if (clear) begin
        col_out <= '0;
      end else begin
        col_out <= col_in;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipd_result_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Small result queue; takes up to two results per cycle, gives one.
module ipd_result_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ipd_pkg::ipd_push_t   push,
  input  wire ipd_pkg::ipd_result_t data_a,
  input  wire ipd_pkg::ipd_result_t data_b,
  output logic                      room2,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ipd_pkg::ipd_result_t      out_data
);

  import ipd_pkg::*;

  ipd_result_t        ent [RQ_DEPTH];
  logic [RQ_AW-1:0]   wr_ptr;
  logic [RQ_AW-1:0]   rd_ptr;
  logic [RQ_AW:0]     count;
  logic [RQ_AW:0]     count_next;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room2     = (count <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign out_data  = ent[rd_ptr];

  assign count_next = count + (RQ_AW+1)'(push.push_a) + (RQ_AW+1)'(push.push_b)
                      - (RQ_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      ent[wr_ptr] <= data_a;
    end
    if (push.push_b) begin
      ent[wr_ptr + RQ_AW'(1)] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_AW'(push.push_a) + RQ_AW'(push.push_b);
      if (pop) begin
        rd_ptr <= rd_ptr + RQ_AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ipd_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int HOLD_LEN      = 150;
  localparam bit [19:0] DIRECTED_FRAME = {5'b00000, 5'b01000, 5'b00010, 5'b00000};

  // Tracks the detector state and queues the reports it should produce.
  class isolation_scoreboard;
    logic [CFG_W-1:0]   rows_reg = CFG_SIZE_RESET;
    logic [CFG_W-1:0]   cols_reg = CFG_SIZE_RESET;
    bit                 above_row [DEF_MAX_COLS];
    bit                 two_above_row [DEF_MAX_COLS];
    bit [5:0]           win = '0;
    int unsigned        row_pos = 0;
    int unsigned        col_pos = 0;
    logic [COUNT_W-1:0] found = '0;
    ipd_result_t        expected_reports[$];
    int unsigned        errors = 0;

    function int unsigned clamp_size(int unsigned v, int unsigned max_v);
      if (v == 0) return 1;
      if (v > max_v) return max_v;
      return v;
    endfunction

    function void set_register(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_FRAME_ROWS) rows_reg = val;
      else cols_reg = val;
    endfunction

    function void absorb_pixel(bit px);
      int unsigned n_rows, n_cols, c;
      bit [2:0]    col_new;
      bit [8:0]    win9;
      bit          hit_now, row_end, frame_end;
      ipd_result_t rep;
      n_rows = clamp_size(32'(rows_reg), DEF_MAX_ROWS);
      n_cols = clamp_size(32'(cols_reg), DEF_MAX_COLS);
      c = (col_pos >= DEF_MAX_COLS) ? DEF_MAX_COLS - 1 : col_pos;
      col_new = {px, above_row[c], two_above_row[c]};
      win9 = {col_new, win};
      // center is the middle bit of the previous column
      hit_now = (row_pos >= 2) && (c >= 2) && (win9 == 9'h002);
      if (hit_now && found < COUNT_MAX) found++;
      two_above_row[c] = above_row[c];
      above_row[c] = px;
      win = {win[2:0], col_new};
      row_end = (c + 1 >= n_cols);
      frame_end = row_end && (row_pos + 1 >= n_rows);
      if (hit_now) begin
        rep.kind = KIND_HIT;
        rep.hit_row = COORD_W'(row_pos - 1);
        rep.hit_col = COORD_W'(c - 1);
        rep.hit_count = found;
        rep.last = !frame_end;
        expected_reports.push_back(rep);
      end
      if (frame_end) begin
        rep.kind = KIND_TOTAL;
        rep.hit_row = '0;
        rep.hit_col = '0;
        rep.hit_count = found;
        rep.last = 1'b1;
        expected_reports.push_back(rep);
        row_pos = 0;
        col_pos = 0;
        found = '0;
        win = '0;
      end else if (row_end) begin
        col_pos = 0;
        row_pos = row_pos + 1;
        win = '0;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ipd_result_t got);
      ipd_result_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected result: expected none, actual k%0d r%0d c%0d n%0d l%0d",
                 $time, got.kind, got.hit_row, got.hit_col, got.hit_count, got.last);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("hit_row", want.hit_row, got.hit_row);
      compare_field("hit_col", want.hit_col, got.hit_col);
      compare_field("hit_count", want.hit_count, got.hit_count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CFG_IW-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               pixel = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [COORD_W-1:0] hit_row;
  logic [COORD_W-1:0] hit_col;
  logic [COUNT_W-1:0] hit_count;
  logic               last;

  isolation_scoreboard iso_board;
  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;
  logic                hold_arm = 1'b0;
  int unsigned         hold_cycles = 0;
  int unsigned         send_modes [4] = '{0, 88, 0, 21};
  int unsigned         stall_modes [4] = '{0, 0, 88, 21};

  isolated_pixel_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .hit_row   (hit_row),
    .hit_col   (hit_col),
    .hit_count (hit_count),
    .last      (last)
  );

  always #10 clk = ~clk;

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        iso_board.check_result(ipd_result_t'({kind, hit_row, hit_col, hit_count, last}));
      if (hold_arm && hold_cycles < HOLD_LEN) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles + 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_pixel(bit px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (in_stall);
    iso_board.absorb_pixel(px);
  endtask

  task automatic send_pixels(int unsigned n, int unsigned density);
    repeat (n) send_pixel($urandom_range(99) < density);
  endtask

  // keep feeding until the raster position wraps to the frame start
  task automatic close_frame(int unsigned density);
    while (iso_board.row_pos != 0 || iso_board.col_pos != 0)
      send_pixel($urandom_range(99) < density);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (iso_board.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    iso_board.set_register(idx, val);
  endtask

  task automatic configure(logic [CFG_W-1:0] rows_v, logic [CFG_W-1:0] cols_v,
                           int unsigned send_pct, int unsigned recv_pct);
    settle();
    set_size(CFG_FRAME_ROWS, rows_v);
    set_size(CFG_FRAME_COLS, cols_v);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned d;
    iso_board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two isolated pixels, the second found on the frame's last pixel
    configure(4, 5, 0, 0);
    for (int i = 19; i >= 0; i--) send_pixel(DIRECTED_FRAME[i]);
    // zero sizes act as one: every pixel ends a frame
    configure(0, 0, 0, 0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b1);

    configure(6, 7, 0, 0);
    send_pixels(168, 15);
    configure(5, 9, 88, 0);
    send_pixels(135, 12);
    configure(8, 4, 0, 88);
    send_pixels(128, 20);
    configure(7, 6, 21, 21);
    send_pixels(126, 10);

    // long hold on the result side with one-pixel frames fills the queue
    configure(0, 0, 0, 0);
    hold_arm <= 1'b1;
    send_pixels(120, 50);

    configure(3, 3, 21, 21);
    send_pixels(90, 10);

    // tall frame cut short by a row count written mid-frame
    configure(2047, 3, 0, 21);
    send_pixels(60, 10);
    settle();
    set_size(CFG_FRAME_ROWS, 2);
    close_frame(10);

    // column count shrunk mid-row
    configure(6, 8, 21, 0);
    send_pixels(20, 15);
    settle();
    set_size(CFG_FRAME_COLS, 3);
    close_frame(15);

    for (int k = 0; k < 8; k++) begin
      d = $urandom_range(5, 35);
      configure(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 10)),
                send_modes[k % 4], stall_modes[k % 4]);
      send_pixels(30, d);
      close_frame(d);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (iso_board.errors == 0 && iso_board.expected_reports.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
